/* design/dork4_pkg.sv */
package dork4_pkg;

	// Default fixed-point format
	localparam int DORK4_FRAC_BITS  = 16;
	localparam int DORK4_WORD_WIDTH = 32;

	// Port widths fixed by the interface
	localparam int IO_W  = 32;
	localparam int CFG_W = 31;
	localparam int IDX_W = 2;

	// Register indexes
	localparam logic [IDX_W-1:0] CFG_STIFFNESS = 2'd0;
	localparam logic [IDX_W-1:0] CFG_DAMPING   = 2'd1;
	localparam logic [IDX_W-1:0] CFG_TIME_STEP = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0] STIFF_RST = 31'd65536;
	localparam logic [CFG_W-1:0] DAMP_RST  = 31'd0;
	localparam logic [CFG_W-1:0] DT_RST    = 31'd655;

	// Request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// Combine modes of the multiply-accumulate unit
	typedef logic [1:0] mac_mode_t;
	localparam mac_mode_t MAC_MUL    = 2'd0;
	localparam mac_mode_t MAC_NEGSUB = 2'd1;
	localparam mac_mode_t MAC_ADD    = 2'd2;

	typedef struct packed {
		logic      start;
		mac_mode_t mode;
	} mac_ctl_t;

	typedef struct packed {
		logic done;
		logic clamped;
	} mac_sts_t;

endpackage

/* design/dork4_mac.sv */
module dork4_mac import dork4_pkg::*; #(
	parameter int FRAC_BITS  = DORK4_FRAC_BITS,
	parameter int WORD_WIDTH = DORK4_WORD_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mac_ctl_t                     ctl,
	input  logic [CFG_W-1:0]             coef,
	input  logic signed [WORD_WIDTH-1:0] val,
	input  logic signed [WORD_WIDTH-1:0] base,
	output mac_sts_t                     sts,
	output logic signed [WORD_WIDTH-1:0] res
);

	localparam int W    = WORD_WIDTH;
	localparam int LO_W = W / 2;
	localparam int HI_W = W - LO_W;
	localparam int E    = W + 32;
	localparam int HP_W = CFG_W + 1 + HI_W;
	localparam int LP_W = CFG_W + LO_W;

	// Clamp a wide value to the word range; top bit flags a clamp
	function automatic logic [W:0] clamp_w(input logic signed [E-1:0] v);
		logic ovf;
		logic [W:0] r;
		ovf = (v[E-1:W-1] != '0) && (v[E-1:W-1] != '1);
		if (ovf) begin
			r = {1'b1, v[E-1], {(W-1){~v[E-1]}}};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	logic [CFG_W-1:0]       coef_q;
	logic [LO_W-1:0]        lo_q;
	mac_mode_t              mode_q;
	logic                   p1_q;
	logic                   done_q;
	logic signed [HP_W-1:0] hi_s1;
	logic signed [E-1:0]    prod_s2;

	logic [LP_W-1:0]     lo_p;
	logic signed [E-1:0] hi_ext;
	logic [E-1:0]        lo_ext;
	logic signed [E-1:0] shifted;
	logic [W:0]          m_c;
	logic signed [W-1:0] m;
	logic signed [E-1:0] comb_full;
	logic [W:0]          r_c;

	// Control: first partial product, then sum, then result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			p1_q   <= ctl.start;
			done_q <= p1_q;
		end
	end

	// High partial product on start, full product in the cycle after
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			coef_q <= coef;
			lo_q   <= val[LO_W-1:0];
			mode_q <= ctl.mode;
			hi_s1  <= $signed({1'b0, coef}) * $signed(val[W-1:LO_W]);
		end
		if (p1_q) begin
			prod_s2 <= hi_ext + $signed(lo_ext);
		end
	end

	assign lo_p   = coef_q * lo_q;
	assign hi_ext = E'(hi_s1) <<< LO_W;
	assign lo_ext = E'(lo_p);

	// Floor shift, clamp, then combine with the base as the mode selects and clamp again
	always_comb begin
		shifted = prod_s2 >>> FRAC_BITS;
		m_c     = clamp_w(shifted);
		m       = m_c[W-1:0];
		unique case (mode_q)
			MAC_NEGSUB: comb_full = -E'(base) - E'(m);
			MAC_ADD:    comb_full = E'(base) + E'(m);
			default:    comb_full = E'(m);
		endcase
		r_c = clamp_w(comb_full);
	end

	assign res         = r_c[W-1:0];
	assign sts.done    = done_q;
	assign sts.clamped = m_c[W] | r_c[W];

	a_done_after_p1: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(p1_q))
		else $error("product ready without a product phase");

	a_p1_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		p1_q |-> $past(ctl.start))
		else $error("product phase without a start");

endmodule

/* design/dork4_div3.sv */
module dork4_div3 import dork4_pkg::*; #(
	parameter int WORD_WIDTH = DORK4_WORD_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [WORD_WIDTH+2:0] sum,
	output logic                         done,
	output logic signed [WORD_WIDTH-1:0] mean
);

	localparam int W     = WORD_WIDTH;
	localparam int ND    = W + 2;
	localparam int DIG   = 4;
	localparam int NSTEP = (ND + DIG - 1) / DIG;
	localparam int NP    = NSTEP * DIG;
	localparam int CNT_W = $clog2(NSTEP + 1);
	localparam logic [ND-1:0] OFFSET = ND'(3) << (W - 1);

	logic [NP-1:0]    dvd_q;
	logic [1:0]       rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic signed [W+2:0] y_half;
	logic [ND-1:0]       y_off;
	logic [DIG-1:0]      qbits;
	logic [1:0]          rem_d;
	logic [2:0]          trial;

	// Halve with floor, then bias so the dividend is never negative
	assign y_half = sum >>> 1;
	assign y_off  = y_half[ND-1:0] + OFFSET;

	// Restoring division by three, DIG quotient bits per cycle
	always_comb begin
		rem_d = rem_q;
		qbits = '0;
		trial = '0;
		for (int j = 0; j < DIG; j++) begin
			trial = {rem_d, dvd_q[NP-1-j]};
			if (trial >= 3'd3) begin
				qbits[DIG-1-j] = 1'b1;
				rem_d          = 2'(trial - 3'd3);
			end else begin
				rem_d = trial[1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NSTEP);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift the dividend out and the quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= NP'(y_off);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[NP-DIG-1:0], qbits};
			rem_q <= rem_d;
		end
	end

	// Remove the bias: subtracting half the range flips the top bit
	assign mean = {~dvd_q[W-1], dvd_q[W-2:0]};
	assign done = done_q;

endmodule

/* design/damped_oscillator_rk4_step.sv */
// Damped oscillator integrator: keeps position, velocity and time as signed
// fixed-point words (WORD_WIDTH bits, FRAC_BITS fraction bits, Q16.16 by
// default) and, per input transaction, either loads all three (req_type 0) or
// runs one classic RK4 step with acceleration -K*x - C*v and adds the time step
// to time (req_type 1). Every transaction returns one result with the new state
// and a flag that is set if any value was clamped to the word range. Products
// round toward minus infinity. A load goes from acceptance straight to the done
// state, which registers the result. A step runs its sixteen products through one
// shared multiply-accumulate unit and the two divisions by six through a serial
// divider that retires 4 quotient bits a cycle; in_stall stays high while a
// transaction is in progress. The user must write registers only while no
// transaction is in progress; the block itself does not enforce this.
module damped_oscillator_rk4_step import dork4_pkg::*; #(
	parameter int FRAC_BITS  = DORK4_FRAC_BITS,
	parameter int WORD_WIDTH = DORK4_WORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [IO_W-1:0]        cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   req_type,
	input  logic signed [IO_W-1:0] load_position,
	input  logic signed [IO_W-1:0] load_velocity,
	input  logic signed [IO_W-1:0] load_time,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [IO_W-1:0] position_out,
	output logic signed [IO_W-1:0] velocity_out,
	output logic signed [IO_W-1:0] time_out,
	output logic                   saturated
);

	localparam int W  = WORD_WIDTH;
	localparam int E  = W + 32;
	localparam int SW = W + 3;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_KX    = 4'd2;
	localparam logic [3:0] S_CV    = 4'd3;
	localparam logic [3:0] S_HX    = 4'd4;
	localparam logic [3:0] S_HV    = 4'd5;
	localparam logic [3:0] S_DX0   = 4'd6;
	localparam logic [3:0] S_DX    = 4'd7;
	localparam logic [3:0] S_DV    = 4'd8;
	localparam logic [3:0] S_FX    = 4'd9;
	localparam logic [3:0] S_FV    = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	// Clamp a wide value to the word range; top bit flags a clamp
	function automatic logic [W:0] clamp_w(input logic signed [E-1:0] v);
		logic ovf;
		logic [W:0] r;
		ovf = (v[E-1:W-1] != '0) && (v[E-1:W-1] != '1);
		if (ovf) begin
			r = {1'b1, v[E-1], {(W-1){~v[E-1]}}};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	logic [CFG_W-1:0] stiff_q;
	logic [CFG_W-1:0] damp_q;
	logic [CFG_W-1:0] dt_q;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] stg_q;
	logic       sat_q;

	logic signed [W-1:0]  pos_q;
	logic signed [W-1:0]  vel_q;
	logic signed [W-1:0]  time_q;
	logic signed [W-1:0]  xs_q;
	logic signed [W-1:0]  vs_q;
	logic signed [W-1:0]  t_q;
	logic signed [W-1:0]  acc_q;
	logic signed [W-1:0]  mx_q;
	logic signed [W-1:0]  mv_q;
	logic signed [SW-1:0] sumx_q;
	logic signed [SW-1:0] sumv_q;

	logic                  out_valid_q;
	logic signed [IO_W-1:0] pos_out_q;
	logic signed [IO_W-1:0] vel_out_q;
	logic signed [IO_W-1:0] time_out_q;
	logic                  sat_out_q;

	logic in_acc;
	logic out_free;

	logic [W:0]          dt_c;
	logic signed [W-1:0] dt_w;
	logic [CFG_W-1:0]    dt_coef;
	logic [CFG_W-1:0]    h_coef;
	logic [CFG_W-1:0]    hc;
	logic [W:0]          ld_pos_c;
	logic [W:0]          ld_vel_c;
	logic [W:0]          ld_time_c;
	logic [W:0]          time_c;

	mac_ctl_t            mac_ctl;
	mac_sts_t            mac_sts;
	logic [CFG_W-1:0]    mac_coef;
	logic signed [W-1:0] mac_val;
	logic signed [W-1:0] mac_base;
	logic signed [W-1:0] mac_res;

	logic                 div_start;
	logic signed [SW-1:0] div_sum;
	logic                 div_done;
	logic signed [W-1:0]  div_mean;

	logic signed [SW-1:0] kx_add;
	logic signed [SW-1:0] kv_add;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Time step clamped to the word, and the half step
	assign dt_c    = clamp_w(E'($signed({1'b0, dt_q})));
	assign dt_w    = dt_c[W-1:0];
	assign dt_coef = CFG_W'(dt_w);
	assign h_coef  = dt_coef >> 1;
	assign hc      = (stg_q == 2'd2) ? dt_coef : h_coef;

	assign ld_pos_c  = clamp_w(E'(load_position));
	assign ld_vel_c  = clamp_w(E'(load_velocity));
	assign ld_time_c = clamp_w(E'(load_time));
	assign time_c    = clamp_w(E'(time_q) + E'(dt_w));

	// Sequencer: one product in flight at a time, next issued on completion
	always_comb begin
		state_d       = state_q;
		mac_ctl.start = 1'b0;
		div_start     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (req_type == REQ_STEP) ? S_START : S_DONE;
				end
			end
			S_START: begin
				state_d       = S_KX;
				mac_ctl.start = 1'b1;
			end
			S_KX: begin
				if (mac_sts.done) begin
					state_d       = S_CV;
					mac_ctl.start = 1'b1;
				end
			end
			S_CV: begin
				if (mac_sts.done) begin
					if (stg_q == 2'd3) begin
						state_d = S_DX0;
					end else begin
						state_d       = S_HX;
						mac_ctl.start = 1'b1;
					end
				end
			end
			S_HX: begin
				if (mac_sts.done) begin
					state_d       = S_HV;
					mac_ctl.start = 1'b1;
				end
			end
			S_HV: begin
				if (mac_sts.done) begin
					state_d       = S_KX;
					mac_ctl.start = 1'b1;
				end
			end
			S_DX0: begin
				state_d   = S_DX;
				div_start = 1'b1;
			end
			S_DX: begin
				if (div_done) begin
					state_d   = S_DV;
					div_start = 1'b1;
				end
			end
			S_DV: begin
				if (div_done) begin
					state_d       = S_FX;
					mac_ctl.start = 1'b1;
				end
			end
			S_FX: begin
				if (mac_sts.done) begin
					state_d       = S_FV;
					mac_ctl.start = 1'b1;
				end
			end
			S_FV: begin
				if (mac_sts.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Operands of the product being issued
	always_comb begin
		mac_coef     = stiff_q;
		mac_val      = xs_q;
		mac_ctl.mode = MAC_MUL;
		unique case (state_d)
			S_CV: begin
				mac_coef     = damp_q;
				mac_val      = vs_q;
				mac_ctl.mode = MAC_NEGSUB;
			end
			S_HX: begin
				mac_coef     = hc;
				mac_val      = vs_q;
				mac_ctl.mode = MAC_ADD;
			end
			S_HV: begin
				mac_coef     = hc;
				mac_val      = acc_q;
				mac_ctl.mode = MAC_ADD;
			end
			S_FX: begin
				mac_coef     = dt_coef;
				mac_val      = mx_q;
				mac_ctl.mode = MAC_ADD;
			end
			S_FV: begin
				mac_coef     = dt_coef;
				mac_val      = mv_q;
				mac_ctl.mode = MAC_ADD;
			end
			default: begin
				mac_coef     = stiff_q;
				mac_val      = xs_q;
				mac_ctl.mode = MAC_MUL;
			end
		endcase
	end

	// Base of the product completing now
	always_comb begin
		unique case (state_q)
			S_CV:       mac_base = t_q;
			S_HX, S_FX: mac_base = pos_q;
			S_HV, S_FV: mac_base = vel_q;
			default:    mac_base = '0;
		endcase
	end

	// Weighted slopes for the running sums: middle stages count twice
	always_comb begin
		kx_add = SW'(vs_q);
		kv_add = SW'(mac_res);
		if (stg_q == 2'd1 || stg_q == 2'd2) begin
			kx_add = kx_add <<< 1;
			kv_add = kv_add <<< 1;
		end
	end

	assign div_sum = (state_q == S_DX0) ? sumx_q : sumv_q;

	dork4_mac #(
		.FRAC_BITS (FRAC_BITS),
		.WORD_WIDTH(WORD_WIDTH)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.coef  (mac_coef),
		.val   (mac_val),
		.base  (mac_base),
		.sts   (mac_sts),
		.res   (mac_res)
	);

	dork4_div3 #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_div3 (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.sum   (div_sum),
		.done  (div_done),
		.mean  (div_mean)
	);

	// Control, registers and oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stg_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			stiff_q     <= STIFF_RST;
			damp_q      <= DAMP_RST;
			dt_q        <= DT_RST;
			pos_q       <= '0;
			vel_q       <= '0;
			time_q      <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_STIFFNESS: stiff_q <= cfg_data[CFG_W-1:0];
					CFG_DAMPING:   damp_q  <= cfg_data[CFG_W-1:0];
					CFG_TIME_STEP: dt_q    <= cfg_data[CFG_W-1:0];
					default:       ;
				endcase
			end

			if (in_acc) begin
				stg_q <= '0;
				if (req_type == REQ_LOAD) begin
					pos_q  <= ld_pos_c[W-1:0];
					vel_q  <= ld_vel_c[W-1:0];
					time_q <= ld_time_c[W-1:0];
					sat_q  <= ld_pos_c[W] | ld_vel_c[W] | ld_time_c[W];
				end else begin
					sat_q <= dt_c[W];
				end
			end

			if (mac_sts.done) begin
				sat_q <= sat_q | mac_sts.clamped;
				if (state_q == S_HV) begin
					stg_q <= stg_q + 2'd1;
				end
				if (state_q == S_FX) begin
					pos_q <= mac_res;
				end
				if (state_q == S_FV) begin
					vel_q  <= mac_res;
					time_q <= time_c[W-1:0];
					sat_q  <= sat_q | mac_sts.clamped | time_c[W];
				end
			end

			// Hold the result until taken, then drop valid
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage values, slope sums and result payload
	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_STEP) begin
			xs_q   <= pos_q;
			vs_q   <= vel_q;
			sumx_q <= '0;
			sumv_q <= '0;
		end
		if (mac_sts.done) begin
			unique case (state_q)
				S_KX: t_q <= mac_res;
				S_CV: begin
					acc_q  <= mac_res;
					sumx_q <= sumx_q + kx_add;
					sumv_q <= sumv_q + kv_add;
				end
				S_HX:    xs_q <= mac_res;
				S_HV:    vs_q <= mac_res;
				default: ;
			endcase
		end
		if (div_done) begin
			if (state_q == S_DX) begin
				mx_q <= div_mean;
			end else begin
				mv_q <= div_mean;
			end
		end
		if (state_q == S_DONE && out_free) begin
			pos_out_q  <= IO_W'(pos_q);
			vel_out_q  <= IO_W'(vel_q);
			time_out_q <= IO_W'(time_q);
			sat_out_q  <= sat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign position_out = pos_out_q;
	assign velocity_out = vel_out_q;
	assign time_out     = time_out_q;
	assign saturated    = sat_out_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done state");

	a_mac_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_sts.done |-> (state_q == S_KX || state_q == S_CV || state_q == S_HX ||
			state_q == S_HV || state_q == S_FX || state_q == S_FV))
		else $error("product completed with no product pending");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DX || state_q == S_DV))
		else $error("division completed with no division pending");

	a_load_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req_type == REQ_LOAD) |=> (state_q == S_DONE))
		else $error("load transaction did not go straight to done");

endmodule
